FILE: rtl/ttr_pkg.sv
// Shared types and constants for the tarpit responder.
package ttr_pkg;
	typedef enum logic [1:0] {
		OP_PACKET = 2'd0,
		OP_LOAD_RAND = 2'd1,
		OP_SET_MARK = 2'd2,
		OP_REFILL = 2'd3
	} opcode_t;

	localparam logic [1:0] PROTO_TCP = 2'd0;
	localparam logic [1:0] PROTO_ICMP = 2'd1;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_RST_ACK = 3'd1;
	localparam logic [2:0] KIND_SYN_ACK = 3'd2;
	localparam logic [2:0] KIND_RST = 3'd3;
	localparam logic [2:0] KIND_PERSIST = 3'd4;
	localparam logic [2:0] KIND_ECHO = 3'd5;

	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	localparam logic [2:0] CFG_THROTTLE = 3'd0;
	localparam logic [2:0] CFG_MAX_BW = 3'd1;
	localparam logic [2:0] CFG_FIREWALL = 3'd2;
	localparam logic [2:0] CFG_NO_RESP = 3'd3;
	localparam logic [2:0] CFG_PERSIST_ONLY = 3'd4;

	localparam logic [16:0] ETH_BYTES = 17'd14;
	localparam logic [17:0] IP_BYTES = 18'd20;
	localparam int PORT_DEPTH = 65536;
	localparam int PORT_AW = 16;
endpackage

FILE: rtl/ttr_ram.sv
// Generic single-port RAM with registered read.
module ttr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/tcp_tarpit_responder_core.sv
// Top level of the tarpit responder: sequencer, port tables and random table scan.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | opcode .. echo_request
//  out     | output    | out_valid/out_ready| reply_kind .. bytes_total
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// After reset the port tables are cleared, one port per cycle, with in_ready
// low. An unblocked TCP packet passes through table read, decision, finish and
// result before the next input transfer; other items go from table read to result.
// A lone ACK on an answering port with max_bw set that is not first data also
// scans the random table, one word per cycle through the shared compare.
// One item is in flight at a time; the result register frees once the out
// transfer is done, and the block waits in the result state while out_ready is low.
module tcp_tarpit_responder_core #(
	parameter int RAND_DEPTH = 16,
	parameter int PORT_LIMIT = 255,
	parameter int NOISE_LEVEL = 3
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [1:0] proto,
	input logic [31:0] src_ip,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [31:0] seq_num,
	input logic [31:0] ack_num,
	input logic [7:0] tcp_flags,
	input logic [15:0] ip_total_len,
	input logic [3:0] tcp_hdr_words,
	input logic address_blocked,
	input logic echo_request,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] reply_kind,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic [31:0] out_seq,
	output logic [31:0] out_ack,
	output logic [15:0] out_window,
	output logic [7:0] out_flags,
	output logic linux_probe,
	output logic [31:0] bytes_total
);
	localparam int RIW = (RAND_DEPTH > 1) ? $clog2(RAND_DEPTH) : 1;
	localparam int RCW = $clog2(RAND_DEPTH + 1);
	localparam logic [7:0] LIMIT = 8'(PORT_LIMIT);
	localparam logic [7:0] NOISE = 8'(NOISE_LEVEL);
	localparam logic [RIW-1:0] LAST_IDX = RIW'(RAND_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_SCAN, ST_FINISH, ST_OUT
	} state_t;

	state_t state_q;
	logic [15:0] clr_q;

	logic [15:0] throttle_q;
	logic [19:0] max_bw_q;
	logic fw_q, nores_q, ponly_q;

	logic [1:0] op_q, proto_q;
	logic [31:0] sip_q, seq_q, ack_q;
	logic [15:0] sp_q, dp_q, tlen_q;
	logic [7:0] fl_q;
	logic [3:0] hw_q;
	logic blk_q, echo_q;

	logic [31:0] rtab_q [RAND_DEPTH];
	logic [RIW-1:0] ridx_q;
	logic signed [31:0] budget_q;
	logic [31:0] sent_q;
	logic [31:0] coded_q, dec_q;
	logic [RCW-1:0] scan_q;
	logic probe_q;

	// port tables
	logic ign_we, cnt_we;
	logic [ttr_pkg::PORT_AW-1:0] tab_addr;
	logic ign_wd, ign_rd;
	logic [7:0] cnt_wd, cnt_rd;

	ttr_ram #(.WIDTH(1), .DEPTH(ttr_pkg::PORT_DEPTH)) u_ign (
		.clk(clk), .we(ign_we), .addr(tab_addr), .wdata(ign_wd), .rdata(ign_rd)
	);
	ttr_ram #(.WIDTH(8), .DEPTH(ttr_pkg::PORT_DEPTH)) u_cnt (
		.clk(clk), .we(cnt_we), .addr(tab_addr), .wdata(cnt_wd), .rdata(cnt_rd)
	);

	logic [7:0] cnt_next;
	logic syn_bit;
	assign syn_bit = fl_q[1];
	assign cnt_next = (cnt_rd < LIMIT && syn_bit) ? cnt_rd + 8'd1 : cnt_rd;

	always_comb begin
		tab_addr = dp_q;
		ign_we = 1'b0;
		cnt_we = 1'b0;
		ign_wd = ack_q[0];
		cnt_wd = cnt_next;
		if (state_q == ST_CLEAR) begin
			tab_addr = clr_q;
			ign_we = 1'b1;
			cnt_we = 1'b1;
			ign_wd = 1'b0;
			cnt_wd = 8'd0;
		end else if (state_q == ST_READ && op_q == ttr_pkg::OP_SET_MARK) begin
			ign_we = 1'b1;
		end else if (state_q == ST_DECIDE && op_q == ttr_pkg::OP_PACKET
				&& proto_q == ttr_pkg::PROTO_TCP && !blk_q && !ign_rd && fw_q) begin
			cnt_we = 1'b1;
		end
	end

	// shared compare unit for the random-table scan
	logic [31:0] scan_word;
	logic scan_hit;
	assign scan_word = rtab_q[scan_q[RIW-1:0]];
	assign scan_hit = ((dec_q ^ scan_word) == seq_q);

	logic [17:0] hsize;
	logic [17:0] tlen_w;
	logic [31:0] charge;
	assign hsize = ttr_pkg::IP_BYTES + {12'd0, hw_q, 2'd0};
	assign tlen_w = {2'd0, tlen_q};
	assign charge = {16'd0, tlen_q} + 32'(ttr_pkg::ETH_BYTES);

	logic tcp_go, echo_go, persist_path, first_data;
	assign tcp_go = (op_q == ttr_pkg::OP_PACKET) && !blk_q && (proto_q == ttr_pkg::PROTO_TCP);
	assign echo_go = (op_q == ttr_pkg::OP_PACKET) && !blk_q
		&& (proto_q == ttr_pkg::PROTO_ICMP) && !nores_q && echo_q;
	// ACK alone on a port that answers, with trapping enabled
	assign persist_path = !ign_rd && (!fw_q || cnt_next > NOISE) && !fl_q[1] && fl_q[4]
		&& (max_bw_q != '0);
	assign first_data = (tlen_w == hsize + {2'd0, throttle_q});

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			throttle_q <= 16'd10;
			max_bw_q <= '0;
			fw_q <= 1'b0;
			nores_q <= 1'b0;
			ponly_q <= 1'b0;
			for (int i = 0; i < RAND_DEPTH; i++) rtab_q[i] <= '0;
			ridx_q <= '0;
			budget_q <= '0;
			sent_q <= '0;
			out_valid <= 1'b0;
			reply_kind <= ttr_pkg::KIND_NONE;
			out_src_port <= '0;
			out_dst_port <= '0;
			out_seq <= '0;
			out_ack <= '0;
			out_window <= '0;
			out_flags <= '0;
			linux_probe <= 1'b0;
			bytes_total <= '0;
			scan_q <= '0;
			probe_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ttr_pkg::CFG_THROTTLE: throttle_q <= cfg_data[15:0];
					ttr_pkg::CFG_MAX_BW: max_bw_q <= cfg_data;
					ttr_pkg::CFG_FIREWALL: fw_q <= cfg_data[0];
					ttr_pkg::CFG_NO_RESP: nores_q <= cfg_data[0];
					ttr_pkg::CFG_PERSIST_ONLY: ponly_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 16'd1;
					if (clr_q == 16'hFFFF) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						proto_q <= proto;
						sip_q <= src_ip;
						sp_q <= src_port;
						dp_q <= dst_port;
						seq_q <= seq_num;
						ack_q <= ack_num;
						fl_q <= tcp_flags;
						tlen_q <= ip_total_len;
						hw_q <= tcp_hdr_words;
						blk_q <= address_blocked;
						echo_q <= echo_request;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// RAM read of dp_q in flight; form coded number
					coded_q <= ((seq_q + {16'd0, throttle_q}) ^ rtab_q[ridx_q]
						^ {sp_q, dp_q} ^ sip_q) - 32'd1;
					dec_q <= ack_q ^ sip_q ^ {sp_q, dp_q};
					reply_kind <= echo_go ? ttr_pkg::KIND_ECHO : ttr_pkg::KIND_NONE;
					out_src_port <= '0;
					out_dst_port <= '0;
					out_seq <= '0;
					out_ack <= '0;
					out_window <= '0;
					out_flags <= '0;
					linux_probe <= 1'b0;
					scan_q <= '0;
					probe_q <= 1'b0;
					state_q <= tcp_go ? ST_DECIDE : ST_OUT;
					case (ttr_pkg::opcode_t'(op_q))
						ttr_pkg::OP_LOAD_RAND: begin
							for (int i = 0; i < RAND_DEPTH; i++)
								if (32'(i) == {16'd0, dp_q}) rtab_q[i] <= seq_q;
						end
						ttr_pkg::OP_REFILL: budget_q <= signed'({12'd0, max_bw_q});
						ttr_pkg::OP_PACKET: begin
							if (tcp_go)
								ridx_q <= (ridx_q == LAST_IDX) ? '0 : ridx_q + RIW'(1);
						end
						default: ;
					endcase
				end
				ST_DECIDE: begin
					state_q <= (persist_path && !first_data) ? ST_SCAN : ST_FINISH;
					out_src_port <= dp_q;
					out_dst_port <= sp_q;
					out_seq <= persist_path ? ack_q : coded_q;
					out_window <= persist_path ? 16'd0 : throttle_q;
					if (!persist_path) out_ack <= seq_q + 32'd1;
					else if (first_data) out_ack <= seq_q + {16'd0, throttle_q};
					else out_ack <= seq_q;
					if (ign_rd) begin
						if (!fw_q) begin
							reply_kind <= ttr_pkg::KIND_RST_ACK;
							out_flags <= ttr_pkg::FLAG_RST | ttr_pkg::FLAG_ACK;
						end
					end else if (!fw_q || cnt_next > NOISE) begin
						case ({fl_q[1], fl_q[4]})
							2'b10: if (!(ponly_q && budget_q <= 0)) begin
								reply_kind <= ttr_pkg::KIND_SYN_ACK;
								out_flags <= ttr_pkg::FLAG_SYN | ttr_pkg::FLAG_ACK;
							end
							2'b11: if (!nores_q) begin
								reply_kind <= ttr_pkg::KIND_RST;
								out_flags <= ttr_pkg::FLAG_RST;
							end
							2'b01: if (max_bw_q != '0) begin
								out_flags <= ttr_pkg::FLAG_ACK;
								if (first_data && budget_q > 0) begin
									reply_kind <= ttr_pkg::KIND_PERSIST;
									budget_q <= budget_q - signed'(charge);
									sent_q <= sent_q + charge;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_q == RCW'(RAND_DEPTH)) begin
						if (tlen_w == hsize + 18'd1 || probe_q) begin
							reply_kind <= ttr_pkg::KIND_PERSIST;
							linux_probe <= probe_q;
							sent_q <= sent_q + charge;
						end
						state_q <= ST_FINISH;
					end else begin
						if (scan_hit) probe_q <= 1'b1;
						scan_q <= scan_q + RCW'(1);
					end
				end
				ST_FINISH: begin
					if (reply_kind == ttr_pkg::KIND_NONE) begin
						out_src_port <= '0;
						out_dst_port <= '0;
						out_seq <= '0;
						out_ack <= '0;
						out_window <= '0;
						out_flags <= '0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						bytes_total <= sent_q;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: tb/tarpit_checker.sv
// Reply predictor and scoreboard for the tarpit responder channels.
module tarpit_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] opcode,
	input logic [1:0] proto,
	input logic [31:0] src_ip,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [31:0] seq_num,
	input logic [31:0] ack_num,
	input logic [7:0] tcp_flags,
	input logic [15:0] ip_total_len,
	input logic [3:0] tcp_hdr_words,
	input logic address_blocked,
	input logic echo_request,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] reply_kind,
	input logic [15:0] out_src_port,
	input logic [15:0] out_dst_port,
	input logic [31:0] out_seq,
	input logic [31:0] out_ack,
	input logic [15:0] out_window,
	input logic [7:0] out_flags,
	input logic linux_probe,
	input logic [31:0] bytes_total,
	output int fail_count,
	output int pending
);
	localparam int RAND_DEPTH = 16;
	localparam int PORT_LIMIT = 255;
	localparam int NOISE_LEVEL = 3;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] win;
		logic [7:0] flags;
		logic probe;
		logic [31:0] bytes;
	} reply_t;

	reply_t replies_q[$];

	logic [31:0] rand_words[RAND_DEPTH];
	logic [3:0] rand_ptr;
	logic ignore_mark[ttr_pkg::PORT_DEPTH];
	logic [7:0] syn_count[ttr_pkg::PORT_DEPTH];
	int budget;
	logic [31:0] trapped;

	logic [15:0] throttle;
	logic [19:0] max_bw;
	logic firewall, silent, persist_only;

	function automatic reply_t tcp_reply(logic [2:0] k, logic [15:0] sp, logic [15:0] dp,
			logic [31:0] sq, logic [31:0] ak, logic [15:0] w, logic [7:0] f, logic p);
		reply_t r;
		r = '0;
		r.kind = k; r.sport = sp; r.dport = dp; r.seq = sq; r.ack = ak;
		r.win = w; r.flags = f; r.probe = p;
		return r;
	endfunction

	function automatic reply_t predict_reply();
		reply_t r;
		logic [31:0] coded, dec, hsize, charge;
		logic [15:0] dp;
		bit probe, quiet;
		r = '0;
		dp = dst_port;
		charge = {16'd0, ip_total_len} + 32'd14;
		case (opcode)
			ttr_pkg::OP_LOAD_RAND: if (dp < RAND_DEPTH) rand_words[dp[3:0]] = seq_num;
			ttr_pkg::OP_SET_MARK: ignore_mark[dp] = ack_num[0];
			ttr_pkg::OP_REFILL: budget = int'({12'd0, max_bw});
			default: begin
				if (!address_blocked && proto == ttr_pkg::PROTO_TCP) begin
					coded = (seq_num + {16'd0, throttle}) ^ rand_words[rand_ptr]
						^ {src_port, dp} ^ src_ip;
					coded = coded - 32'd1;
					rand_ptr = rand_ptr + 4'd1;
					if (ignore_mark[dp]) begin
						if (!firewall)
							r = tcp_reply(ttr_pkg::KIND_RST_ACK, dp, src_port, coded,
								seq_num + 32'd1, throttle,
								ttr_pkg::FLAG_RST | ttr_pkg::FLAG_ACK, 1'b0);
					end else begin
						quiet = 0;
						if (firewall) begin
							if (syn_count[dp] < PORT_LIMIT && tcp_flags[1])
								syn_count[dp] = syn_count[dp] + 8'd1;
							if (syn_count[dp] <= NOISE_LEVEL) quiet = 1;
						end
						if (!quiet) case ({tcp_flags[4], tcp_flags[1]})
							2'b01: if (!(persist_only && budget <= 0))
								r = tcp_reply(ttr_pkg::KIND_SYN_ACK, dp, src_port, coded,
									seq_num + 32'd1, throttle,
									ttr_pkg::FLAG_SYN | ttr_pkg::FLAG_ACK, 1'b0);
							2'b11: if (!silent)
								r = tcp_reply(ttr_pkg::KIND_RST, dp, src_port, coded,
									seq_num + 32'd1, throttle, ttr_pkg::FLAG_RST, 1'b0);
							2'b10: if (max_bw != 0) begin
								hsize = 32'd20 + {26'd0, tcp_hdr_words, 2'b00};
								if ({16'd0, ip_total_len} == hsize + {16'd0, throttle}) begin
									// first data: charged against the budget
									if (budget > 0) begin
										budget = budget - int'(charge);
										r = tcp_reply(ttr_pkg::KIND_PERSIST, dp, src_port,
											ack_num, seq_num + {16'd0, throttle}, 16'd0,
											ttr_pkg::FLAG_ACK, 1'b0);
										trapped = trapped + charge;
									end
								end else begin
									dec = ack_num ^ src_ip ^ {src_port, dp};
									probe = 0;
									for (int i = 0; i < RAND_DEPTH; i++)
										if ((dec ^ rand_words[i]) == seq_num) probe = 1;
									if ({16'd0, ip_total_len} == hsize + 32'd1 || probe) begin
										r = tcp_reply(ttr_pkg::KIND_PERSIST, dp, src_port,
											ack_num, seq_num, 16'd0, ttr_pkg::FLAG_ACK, probe);
										trapped = trapped + charge;
									end
								end
							end
							default: ;
						endcase
					end
				end else if (!address_blocked && proto == ttr_pkg::PROTO_ICMP && !silent
						&& echo_request)
					r.kind = ttr_pkg::KIND_ECHO;
			end
		endcase
		r.bytes = trapped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < RAND_DEPTH; i++) rand_words[i] = '0;
			for (int i = 0; i < ttr_pkg::PORT_DEPTH; i++) begin
				ignore_mark[i] = 1'b0;
				syn_count[i] = '0;
			end
			rand_ptr = '0;
			budget = 0;
			trapped = '0;
			throttle = 16'd10;
			max_bw = '0;
			firewall = 0; silent = 0; persist_only = 0;
			fail_count <= 0;
			pending <= 0;
			replies_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ttr_pkg::CFG_THROTTLE: throttle = cfg_data[15:0];
					ttr_pkg::CFG_MAX_BW: max_bw = cfg_data;
					ttr_pkg::CFG_FIREWALL: firewall = cfg_data[0];
					ttr_pkg::CFG_NO_RESP: silent = cfg_data[0];
					ttr_pkg::CFG_PERSIST_ONLY: persist_only = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {reply_kind, out_src_port, out_dst_port, out_seq, out_ack, out_window,
					out_flags, linux_probe, bytes_total};
				if (replies_q.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected reply transfer, got %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = replies_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("ERROR: reply mismatch\n  expected %p\n  actual   %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				replies_q.push_back(predict_reply());
			pending <= replies_q.size();
		end
	end
endmodule

FILE: tb/testbench.sv
// Stimulus and verdict for the tarpit responder core.
module testbench;
	typedef struct {
		logic [1:0] op;
		logic [1:0] pr;
		logic [31:0] sip;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [31:0] sq;
		logic [31:0] ak;
		logic [7:0] fl;
		logic [15:0] tl;
		logic [3:0] hw;
		logic blk;
		logic echo;
	} pkt_t;

	logic clk = 0;
	logic arst_n;
	logic in_valid, in_ready;
	logic [1:0] opcode, proto;
	logic [31:0] src_ip, seq_num, ack_num;
	logic [15:0] src_port, dst_port, ip_total_len;
	logic [7:0] tcp_flags;
	logic [3:0] tcp_hdr_words;
	logic address_blocked, echo_request;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;
	logic out_valid, out_ready;
	logic [2:0] reply_kind;
	logic [15:0] out_src_port, out_dst_port, out_window;
	logic [31:0] out_seq, out_ack, bytes_total;
	logic [7:0] out_flags;
	logic linux_probe;
	int fail_count, pending;

	logic [31:0] table_copy[16];
	logic [15:0] port_pool[8];
	logic [15:0] cur_throttle;

	always #5 clk = ~clk;

	tcp_tarpit_responder_core dut (.*);

	tarpit_checker chk (.*);

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int draw_wait();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
	endfunction

	initial begin
		int n;
		out_ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			n = draw_wait();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send(pkt_t p);
		int n;
		n = draw_wait();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= p.op; proto <= p.pr; src_ip <= p.sip; src_port <= p.sp;
		dst_port <= p.dp; seq_num <= p.sq; ack_num <= p.ak; tcp_flags <= p.fl;
		ip_total_len <= p.tl; tcp_hdr_words <= p.hw; address_blocked <= p.blk;
		echo_request <= p.echo;
		do @(posedge clk); while (!in_ready);
		if (p.op == ttr_pkg::OP_LOAD_RAND && p.dp < 16) table_copy[p.dp[3:0]] = p.sq;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ttr_pkg::CFG_THROTTLE) cur_throttle = val[15:0];
	endtask

	task automatic configure(logic [15:0] thr, logic [19:0] bw, logic fw, logic nr, logic po);
		drain();
		write_reg(ttr_pkg::CFG_THROTTLE, {4'd0, thr});
		write_reg(ttr_pkg::CFG_MAX_BW, bw);
		write_reg(ttr_pkg::CFG_FIREWALL, {19'd0, fw});
		write_reg(ttr_pkg::CFG_NO_RESP, {19'd0, nr});
		write_reg(ttr_pkg::CFG_PERSIST_ONLY, {19'd0, po});
		cfg_valid <= 1'b0;
	endtask

	function automatic pkt_t tcp_pkt(logic [15:0] dp, logic [7:0] fl);
		pkt_t p;
		p.op = ttr_pkg::OP_PACKET; p.pr = ttr_pkg::PROTO_TCP; p.sip = $urandom;
		p.sp = 16'($urandom);
		p.dp = dp; p.sq = $urandom; p.ak = $urandom; p.fl = fl;
		p.hw = 4'($urandom_range(5, 15)); p.tl = 16'($urandom); p.blk = 0;
		p.echo = 1'($urandom);
		return p;
	endfunction

	function automatic pkt_t ack_pkt(logic [15:0] dp, int style);
		pkt_t p;
		logic [31:0] hs;
		p = tcp_pkt(dp, ttr_pkg::FLAG_ACK | (8'($urandom) & 8'hED));
		hs = 32'd20 + 4 * p.hw;
		case (style)
			0: if (hs + cur_throttle <= 32'hFFFF) p.tl = 16'(hs + cur_throttle);
			1: p.tl = 16'(hs + 1);
			2: p.sq = p.ak ^ p.sip ^ {p.sp, p.dp} ^ table_copy[$urandom_range(0, 15)];
			default: ;
		endcase
		return p;
	endfunction

	function automatic pkt_t ctl_pkt(logic [1:0] op, logic [15:0] dp);
		pkt_t p;
		p = tcp_pkt(dp, 8'($urandom));
		p.op = op; p.pr = 2'($urandom);
		return p;
	endfunction

	function automatic logic [15:0] pick_port();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
	endfunction

	function automatic pkt_t random_item();
		int r;
		pkt_t p;
		r = $urandom_range(0, 99);
		if (r < 8) p = ctl_pkt(ttr_pkg::OP_LOAD_RAND, ($urandom_range(0, 7) == 0)
			? 16'($urandom) : 16'($urandom_range(0, 15)));
		else if (r < 13) p = ctl_pkt(ttr_pkg::OP_SET_MARK, pick_port());
		else if (r < 18) p = ctl_pkt(ttr_pkg::OP_REFILL, 16'($urandom));
		else if (r < 25) begin
			p = tcp_pkt(pick_port(), 8'($urandom));
			p.pr = 2'($urandom_range(1, 3));
			p.echo = $urandom_range(0, 3) != 0;
		end else if (r < 45)
			p = tcp_pkt(pick_port(), ttr_pkg::FLAG_SYN | (8'($urandom) & 8'hED));
		else if (r < 55)
			p = tcp_pkt(pick_port(),
				ttr_pkg::FLAG_SYN | ttr_pkg::FLAG_ACK | (8'($urandom) & 8'hED));
		else if (r < 90) p = ack_pkt(pick_port(), $urandom_range(0, 3));
		else p = tcp_pkt(pick_port(), 8'($urandom));
		if (p.op == ttr_pkg::OP_PACKET) p.blk = $urandom_range(0, 15) == 0;
		return p;
	endfunction

	initial begin
		pkt_t p;
		logic [15:0] thr_set[7];
		logic [19:0] bw_set[7];
		thr_set = '{16'd10, 16'd0, 16'hFFFF, 16'd40, 16'd1, 16'd200, 16'd10};
		bw_set = '{20'd0, 20'hFFFFF, 20'd3000, 20'd500, 20'hFFFFF, 20'd0, 20'd9000};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		opcode <= '0; proto <= '0; src_ip <= '0; src_port <= '0; dst_port <= '0;
		seq_num <= '0; ack_num <= '0; tcp_flags <= '0; ip_total_len <= '0;
		tcp_hdr_words <= 4'd5; address_blocked <= 1'b0; echo_request <= 1'b0;
		cfg_index <= '0; cfg_data <= '0;
		cur_throttle = 16'd10;
		for (int i = 0; i < 16; i++) table_copy[i] = '0;
		port_pool[0] = 16'd0;
		port_pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset defaults first
		p = tcp_pkt(16'd0, ttr_pkg::FLAG_SYN); p.sip = '0; p.sq = '1; send(p);
		p = tcp_pkt(16'hFFFF, ttr_pkg::FLAG_SYN | ttr_pkg::FLAG_ACK);
		p.sip = '1; p.sp = '1; send(p);
		p = ack_pkt(16'd80, 1); send(p);
		p = tcp_pkt(16'd80, 8'h00); send(p);
		p = tcp_pkt(16'd80, 8'hFF); send(p);
		p = tcp_pkt(16'd80, ttr_pkg::FLAG_SYN); p.blk = 1; send(p);
		p = tcp_pkt(16'd80, ttr_pkg::FLAG_SYN); p.pr = 2'd2; send(p);
		p = tcp_pkt(16'd80, ttr_pkg::FLAG_SYN); p.pr = 2'd3; send(p);
		p = tcp_pkt(16'd80, 8'h00); p.pr = ttr_pkg::PROTO_ICMP; p.echo = 1; send(p);
		p = tcp_pkt(16'd80, 8'h00); p.pr = ttr_pkg::PROTO_ICMP; p.echo = 0; send(p);
		p = ctl_pkt(ttr_pkg::OP_LOAD_RAND, 16'd15); p.sq = '1; send(p);
		p = ctl_pkt(ttr_pkg::OP_LOAD_RAND, 16'd16); send(p);
		p = ctl_pkt(ttr_pkg::OP_LOAD_RAND, 16'd0); send(p);
		p = ctl_pkt(ttr_pkg::OP_SET_MARK, 16'd23); p.ak = 32'd1; send(p);
		p = tcp_pkt(16'd23, ttr_pkg::FLAG_SYN); send(p);
		configure(16'd10, 20'hFFFFF, 1'b0, 1'b0, 1'b1);
		p = tcp_pkt(16'd81, ttr_pkg::FLAG_SYN); send(p);
		p = ctl_pkt(ttr_pkg::OP_REFILL, 16'd0); send(p);
		p = ack_pkt(16'd81, 0); send(p);
		p = ack_pkt(16'd81, 2); send(p);
		p = ack_pkt(16'd81, 1); p.hw = 4'd15; p.tl = 16'd81; send(p);
		configure(16'd10, 20'd5, 1'b1, 1'b1, 1'b1);
		for (int i = 0; i < 5; i++) begin
			p = tcp_pkt(16'd81, ttr_pkg::FLAG_SYN); send(p);
		end
		p = tcp_pkt(16'd23, ttr_pkg::FLAG_SYN); send(p);
		p = tcp_pkt(16'd81, ttr_pkg::FLAG_SYN | ttr_pkg::FLAG_ACK); send(p);
		p = tcp_pkt(16'd81, 8'h00); p.pr = ttr_pkg::PROTO_ICMP; p.echo = 1; send(p);

		for (int ph = 0; ph < 7; ph++) begin
			configure((ph == 6) ? 16'($urandom) : thr_set[ph],
				(ph == 6) ? 20'($urandom) : bw_set[ph],
				(ph == 0) ? 1'b0 : (ph == 4) ? 1'b1 : 1'($urandom),
				(ph == 0) ? 1'b0 : (ph == 4) ? 1'b1 : 1'($urandom),
				(ph == 0) ? 1'b0 : (ph == 4) ? 1'b1 : 1'($urandom));
			for (int i = 0; i < 200; i++) send(random_item());
		end

		drain();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
